@@ design/utfs_pkg.sv @@
// ----------------------------------------------------------------------------
// utfs_pkg
// shared types and constants of the utf-8 text sanitizer
// ----------------------------------------------------------------------------
package utfs_pkg;

	// field widths
	localparam int BYTE_W   = 8;
	localparam int CHAR_W   = 32;
	localparam int LEN_W    = 3;
	localparam int CP_W     = 21;
	localparam int REP_W    = 16;
	localparam int CNT_W    = REP_W + 1;
	localparam int CFG_IDX_W = 3;

	// decoupling queue between front and back
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_STRIP_BOM       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DROP_ZERO_WIDTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DROP_CONTROL    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE_WS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_REPEAT      = 3'd4;

	// decoder constants
	localparam logic [BYTE_W-1:0] TWO_LEAD_MIN  = 8'hC2;
	localparam logic [BYTE_W-1:0] FOUR_LEAD_MAX = 8'hF4;

	// code points
	localparam logic [CP_W-1:0] CP_BOM   = 21'h00FEFF;
	localparam logic [CP_W-1:0] CP_ZW_LO = 21'h00200B;
	localparam logic [CP_W-1:0] CP_ZW_HI = 21'h00200F;
	localparam logic [CP_W-1:0] CP_WJ    = 21'h002060;
	localparam logic [CP_W-1:0] CP_SPACE = 21'h000020;
	localparam logic [CP_W-1:0] CP_TAB   = 21'h000009;
	localparam logic [CP_W-1:0] CP_LF    = 21'h00000A;
	localparam logic [CP_W-1:0] CP_CR    = 21'h00000D;
	localparam logic [BYTE_W-1:0] B_DEL  = 8'h7F;

	localparam logic [CNT_W-1:0] REPEAT_SAT = 17'h10000;

	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              in_last;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_bytes;
		logic [LEN_W-1:0]  char_len;
		logic              end_of_text;
	} out_item_t;

	typedef struct packed {
		logic             strip_bom;
		logic             drop_zero_width;
		logic             drop_control;
		logic             normalize_ws;
		logic [REP_W-1:0] max_repeat;
	} cfg_t;

	// classified event handed from front to back
	typedef struct packed {
		logic              malf;      // malformed input seen before the character
		logic              has_char;  // a complete character is carried
		logic              first;     // character is the first of the text
		logic              last;      // closes the text
		logic [CHAR_W-1:0] bytes;
		logic [LEN_W-1:0]  len;
		logic [CP_W-1:0]   cp;
	} q_item_t;

endpackage

@@ design/utfs_front.sv @@
// ----------------------------------------------------------------------------
// utfs_front
// byte decoder: assembles utf-8 sequences and classifies each input beat
// ----------------------------------------------------------------------------
module utfs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  utfs_pkg::in_item_t  in_data,
	input  logic                q_full,
	output logic                in_ready,
	output logic                push,
	output utfs_pkg::q_item_t   push_item
);

	logic [utfs_pkg::BYTE_W-1:0] pend_q [3];
	logic [utfs_pkg::LEN_W-1:0]  exp_q;
	logic [1:0]                  coll_q;
	logic                        start_q;

	logic                        acc;
	logic [utfs_pkg::BYTE_W-1:0] b;
	logic                        is_cont;
	logic                        cont_ok;
	logic                        broken;
	logic                        done;
	logic [utfs_pkg::LEN_W-1:0]  coll_inc;
	logic [utfs_pkg::LEN_W-1:0]  lead_len;
	logic                        bad_lead;
	logic                        one;
	logic                        malf;
	logic                        has_char;

	function automatic logic [utfs_pkg::LEN_W-1:0] lead_length(
		input logic [utfs_pkg::BYTE_W-1:0] x
	);
		logic [utfs_pkg::LEN_W-1:0] r;
		r = 3'd0;
		if (x[7] == 1'b0) begin
			r = 3'd1;
		end else if (x[7:5] == 3'b110) begin
			r = (x >= utfs_pkg::TWO_LEAD_MIN) ? 3'd2 : 3'd0;
		end else if (x[7:4] == 4'b1110) begin
			r = 3'd3;
		end else if (x[7:3] == 5'b11110) begin
			r = (x <= utfs_pkg::FOUR_LEAD_MAX) ? 3'd4 : 3'd0;
		end
		return r;
	endfunction

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;
	assign b        = in_data.in_byte;

	always_comb begin
		is_cont  = (b[7:6] == 2'b10);
		cont_ok  = (exp_q != '0) && is_cont;
		broken   = (exp_q != '0) && !is_cont;
		coll_inc = {1'b0, coll_q} + 3'd1;
		done     = cont_ok && (coll_inc >= exp_q);
		lead_len = lead_length(b);
		bad_lead = !cont_ok && (lead_len == 3'd0);
		one      = !cont_ok && (lead_len == 3'd1);
		malf     = broken || bad_lead;
		has_char = done || one;

		push_item.malf     = malf;
		push_item.has_char = has_char;
		push_item.first    = start_q && !malf;
		push_item.last     = in_data.in_last;
		push_item.len      = one ? 3'd1 : exp_q;
		push_item.bytes    = {24'd0, b};
		push_item.cp       = {13'd0, b};
		if (done) begin
			case (exp_q)
				3'd2: begin
					push_item.bytes = {16'd0, b, pend_q[0]};
					push_item.cp    = {10'd0, pend_q[0][4:0], b[5:0]};
				end
				3'd3: begin
					push_item.bytes = {8'd0, b, pend_q[1], pend_q[0]};
					push_item.cp    = {5'd0, pend_q[0][3:0], pend_q[1][5:0], b[5:0]};
				end
				3'd4: begin
					push_item.bytes = {b, pend_q[2], pend_q[1], pend_q[0]};
					push_item.cp    = {pend_q[0][2:0], pend_q[1][5:0], pend_q[2][5:0], b[5:0]};
				end
				default: begin
					push_item.bytes = {24'd0, b};
					push_item.cp    = {13'd0, b};
				end
			endcase
		end
		push = acc && (malf || has_char || in_data.in_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q   <= '0;
			coll_q  <= '0;
			start_q <= 1'b1;
		end else if (acc) begin
			if (in_data.in_last) begin
				exp_q   <= '0;
				coll_q  <= '0;
				start_q <= 1'b1;
			end else begin
				start_q <= start_q && !malf && !has_char;
				if (cont_ok) begin
					if (done) begin
						exp_q  <= '0;
						coll_q <= '0;
					end else begin
						coll_q <= coll_inc[1:0];
					end
				end else if (lead_len >= 3'd2) begin
					exp_q  <= lead_len;
					coll_q <= 2'd1;
				end else begin
					exp_q  <= '0;
					coll_q <= '0;
				end
			end
		end
	end

	// pending bytes are payload only
	always_ff @(posedge clk) begin
		if (acc) begin
			if (cont_ok && !done) begin
				pend_q[coll_q] <= b;
			end else if (!cont_ok && lead_len >= 3'd2) begin
				pend_q[0] <= b;
			end
		end
	end

`ifndef SYNTHESIS
	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_data.in_last) |=> (start_q && exp_q == '0 && coll_q == '0))
		else $error("decoder not back at text start after last byte");
	a_coll_below_exp: assert property (@(posedge clk) disable iff (!arst_n)
		(exp_q != '0) |-> ({1'b0, coll_q} < exp_q && coll_q != 2'd0))
		else $error("collected count out of range for pending sequence");
`endif

endmodule

@@ design/utfs_queue.sv @@
// ----------------------------------------------------------------------------
// utfs_queue
// short fifo of classified events between decoder and filter
// ----------------------------------------------------------------------------
module utfs_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  utfs_pkg::q_item_t  push_item,
	input  logic               pop,
	output utfs_pkg::q_item_t  head,
	output logic               head_valid,
	output logic               full
);

	utfs_pkg::q_item_t                mem_q [utfs_pkg::QDEPTH];
	logic [utfs_pkg::QPTR_W-1:0]      wr_q;
	logic [utfs_pkg::QPTR_W-1:0]      rd_q;
	logic [utfs_pkg::QCNT_W-1:0]      cnt_q;

	function automatic logic [utfs_pkg::QPTR_W-1:0] ptr_next(
		input logic [utfs_pkg::QPTR_W-1:0] p
	);
		return (p == utfs_pkg::QPTR_W'(utfs_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head       = mem_q[rd_q];
	assign head_valid = (cnt_q != '0);
	assign full       = (cnt_q == utfs_pkg::QCNT_W'(utfs_pkg::QDEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ptr_next(wr_q);
			end
			if (pop) begin
				rd_q <= ptr_next(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && !head_valid))
		else $error("queue pushed while full or popped while empty");
`endif

endmodule

@@ design/utfs_back.sv @@
// ----------------------------------------------------------------------------
// utfs_back
// character filter: clean-up rules, whitespace folding, repeat limit
// ----------------------------------------------------------------------------
module utfs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  utfs_pkg::cfg_t      cfg,
	input  utfs_pkg::q_item_t   head,
	input  logic                head_valid,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output utfs_pkg::out_item_t out_data
);

	logic                         prev_ws_q;
	logic [utfs_pkg::CP_W-1:0]    prev_cp_q;
	logic [utfs_pkg::LEN_W-1:0]   prev_len_q;
	logic [utfs_pkg::CNT_W-1:0]   rep_q;
	logic                         out_valid_q;
	utfs_pkg::out_item_t          out_s1;

	logic                         pw;
	logic                         pre_drop;
	logic                         is_ws;
	logic                         ws_drop;
	logic                         reached;
	logic                         same;
	logic                         emit;
	logic [utfs_pkg::CP_W-1:0]    ocp;
	logic [utfs_pkg::LEN_W-1:0]   olen;
	logic [utfs_pkg::CHAR_W-1:0]  obytes;
	logic                         pw_n;
	logic [utfs_pkg::CNT_W-1:0]   rep_n;
	logic [utfs_pkg::BYTE_W-1:0]  b0;

	always_comb begin
		b0  = head.bytes[7:0];
		pw  = head.malf ? 1'b0 : prev_ws_q;
		pre_drop = (cfg.strip_bom && head.first && head.len == 3'd3
				&& head.cp == utfs_pkg::CP_BOM)
			|| (cfg.drop_zero_width && ((head.cp >= utfs_pkg::CP_ZW_LO
				&& head.cp <= utfs_pkg::CP_ZW_HI) || head.cp == utfs_pkg::CP_WJ
				|| head.cp == utfs_pkg::CP_BOM))
			|| (cfg.drop_control && head.len == 3'd1
				&& ((b0 < 8'h20 && b0 != 8'h09 && b0 != 8'h0A && b0 != 8'h0D)
				|| b0 == utfs_pkg::B_DEL));
		is_ws = cfg.normalize_ws && (head.cp == utfs_pkg::CP_SPACE
			|| head.cp == utfs_pkg::CP_TAB || head.cp == utfs_pkg::CP_LF
			|| head.cp == utfs_pkg::CP_CR);
		ws_drop = is_ws && pw;

		if (is_ws) begin
			ocp = (head.cp == utfs_pkg::CP_SPACE || head.cp == utfs_pkg::CP_TAB)
				? utfs_pkg::CP_SPACE : utfs_pkg::CP_LF;
			olen   = 3'd1;
			obytes = {11'd0, ocp};
		end else begin
			ocp    = head.cp;
			olen   = head.len;
			obytes = head.bytes;
		end

		// repeat counter runs on every character that reaches it
		reached = head.has_char && !pre_drop && !ws_drop;
		same    = (prev_len_q == olen) && (prev_cp_q == ocp);
		if (same) begin
			rep_n = (rep_q < utfs_pkg::REPEAT_SAT) ? rep_q + 1'b1 : rep_q;
		end else begin
			rep_n = utfs_pkg::CNT_W'(1);
		end
		emit = reached && !(cfg.max_repeat != '0 && rep_n > {1'b0, cfg.max_repeat});

		pw_n = pw;
		if (head.has_char && !pre_drop && !ws_drop) begin
			pw_n = is_ws;
		end

		pop = head_valid && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ws_q   <= 1'b0;
			prev_cp_q   <= '0;
			prev_len_q  <= '0;
			rep_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= emit || head.last;
				if (head.last) begin
					prev_ws_q  <= 1'b0;
					prev_cp_q  <= '0;
					prev_len_q <= '0;
					rep_q      <= '0;
				end else begin
					prev_ws_q <= pw_n;
					if (reached) begin
						rep_q      <= rep_n;
						prev_cp_q  <= ocp;
						prev_len_q <= olen;
					end
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_s1.char_bytes  <= emit ? obytes : '0;
			out_s1.char_len    <= emit ? olen : '0;
			out_s1.end_of_text <= head.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_s1;

`ifndef SYNTHESIS
	a_rep_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		rep_q <= utfs_pkg::REPEAT_SAT)
		else $error("repeat counter beyond saturation");
	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.char_len == '0) |-> out_data.end_of_text)
		else $error("empty result without end of text");
`endif

endmodule

@@ design/utf8_text_sanitizer_unit.sv @@
// ----------------------------------------------------------------------------
// utf8_text_sanitizer_unit
// utf-8 decoder and text sanitizer, one byte per beat in, one character out
// ----------------------------------------------------------------------------
// bytes of a text enter on the in channel, the final one flagged by in_last.
// malformed bytes are dropped, surviving characters leave as one out beat of
// up to four bytes, and every last byte closes the text with end_of_text set
// (char_len 0 when that byte produced no character). while out is accepted the
// block sustains one byte per clock: the decoder front takes a byte every
// cycle while its four-entry event queue has room, and the filter back
// retires one event per cycle into a single output register while that
// is free or taken. a character passes the queue, then the output register.
// configuration registers are written through the cfg channel (always ready)
// and must only change while the block is idle.
// ----------------------------------------------------------------------------
module utf8_text_sanitizer_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// byte input
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  utfs_pkg::in_item_t                     in_data,
	// character output
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output utfs_pkg::out_item_t                    out_data,
	// register writes
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [utfs_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [utfs_pkg::REP_W-1:0]             cfg_data
);

	utfs_pkg::cfg_t     cfg_q;
	logic               push;
	utfs_pkg::q_item_t  push_item;
	logic               q_full;
	logic               pop;
	utfs_pkg::q_item_t  head;
	logic               head_valid;

	// register file: indexes outside the list are ignored
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.strip_bom       <= 1'b1;
			cfg_q.drop_zero_width <= 1'b1;
			cfg_q.drop_control    <= 1'b1;
			cfg_q.normalize_ws    <= 1'b0;
			cfg_q.max_repeat      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				utfs_pkg::CFG_STRIP_BOM:       cfg_q.strip_bom       <= cfg_data[0];
				utfs_pkg::CFG_DROP_ZERO_WIDTH: cfg_q.drop_zero_width <= cfg_data[0];
				utfs_pkg::CFG_DROP_CONTROL:    cfg_q.drop_control    <= cfg_data[0];
				utfs_pkg::CFG_NORMALIZE_WS:    cfg_q.normalize_ws    <= cfg_data[0];
				utfs_pkg::CFG_MAX_REPEAT:      cfg_q.max_repeat      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front: sequence assembly and classification of each byte
	utfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.q_full    (q_full),
		.in_ready  (in_ready),
		.push      (push),
		.push_item (push_item)
	);

	// decoupling queue of classified events
	utfs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (q_full)
	);

	// back: filters, whitespace folding, repeat limit, output register
	utfs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

`ifndef SYNTHESIS
	// a result never claims more than four bytes
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.char_len <= 3'd4))
		else $error("character length out of range");
`endif

endmodule
